// ----- design/kmp_pkg.sv -----
`default_nettype none
package kmp_pkg;

    localparam int BUFFER_DEPTH_DEF = 32;

    localparam int KEY_W  = 8;
    localparam int MOD_W  = 8;
    localparam int ACT_W  = 4;
    localparam int CFG_W  = 8;
    localparam int IDX_W  = 8;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 16;

    // Kinds of queued words, decided by the front end.
    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_TICK   = 2'd1;
    localparam logic [1:0] KIND_HOLD   = 2'd2;

    localparam logic [ACT_W-1:0] ACT_NONE     = 4'd0;
    localparam logic [ACT_W-1:0] ACT_MODS     = 4'd1;
    localparam logic [ACT_W-1:0] ACT_KEY_DN   = 4'd2;
    localparam logic [ACT_W-1:0] ACT_KEY_UP   = 4'd3;
    localparam logic [ACT_W-1:0] ACT_MEDIA_DN = 4'd4;
    localparam logic [ACT_W-1:0] ACT_MEDIA_UP = 4'd5;
    localparam logic [ACT_W-1:0] ACT_POWER_DN = 4'd6;
    localparam logic [ACT_W-1:0] ACT_POWER_UP = 4'd7;
    localparam logic [ACT_W-1:0] ACT_FINISHED = 4'd8;
    localparam logic [ACT_W-1:0] ACT_ACCEPTED = 4'd9;
    localparam logic [ACT_W-1:0] ACT_REJECTED = 4'd10;

    localparam logic [IDX_W-1:0] REG_MEDIA_FIRST = 8'd0;
    localparam logic [IDX_W-1:0] REG_MEDIA_LAST  = 8'd1;
    localparam logic [IDX_W-1:0] REG_POWER_FIRST = 8'd2;
    localparam logic [IDX_W-1:0] REG_POWER_LAST  = 8'd3;

    localparam logic [CFG_W-1:0] MEDIA_FIRST_RST = 8'd128;
    localparam logic [CFG_W-1:0] MEDIA_LAST_RST  = 8'd143;
    localparam logic [CFG_W-1:0] POWER_FIRST_RST = 8'd144;
    localparam logic [CFG_W-1:0] POWER_LAST_RST  = 8'd146;

    localparam logic [KEY_W-1:0] KEY_PAUSE = 8'h01;
    localparam logic [KEY_W-1:0] KEY_HIGH  = 8'h80;

    typedef struct packed {
        logic [1:0]       kind;
        logic [KEY_W-1:0] key;
        logic [MOD_W-1:0] mods;
    } t_item;

endpackage
`default_nettype wire

// ----- design/kmp_front.sv -----
`default_nettype none
module kmp_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_s_tvalid,
    output logic                         o_s_tready,
    input  wire  [kmp_pkg::S_DATA_W-1:0] i_s_tdata,
    input  wire                          i_s_tuser,
    output logic                         o_push,
    output kmp_pkg::t_item               o_item,
    input  wire                          i_q_ready
);
    import kmp_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    // A tick while the host is busy does nothing, so it is marked here and
    // the back end only reports it.
    always_comb begin
        n_item.key  = i_s_tdata[7:0];
        n_item.mods = i_s_tdata[15:8];
        if (!i_s_tuser) begin
            n_item.kind = KIND_APPEND;
        end else if (i_s_tdata[16]) begin
            n_item.kind = KIND_HOLD;
        end else begin
            n_item.kind = KIND_TICK;
        end
    end

    assign o_s_tready = !r_valid || i_q_ready;
    assign o_push     = r_valid && i_q_ready;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

// ----- design/kmp_queue.sv -----
`default_nettype none
module kmp_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  kmp_pkg::t_item  i_item,
    output logic            o_ready,
    output logic            o_valid,
    output kmp_pkg::t_item  o_item,
    input  wire             i_pop
);
    import kmp_pkg::*;

    t_item      r_slot [0:1];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

// ----- design/kmp_back.sv -----
`default_nettype none
module kmp_back #(
    parameter int BUFFER_DEPTH = kmp_pkg::BUFFER_DEPTH_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_q_valid,
    input  kmp_pkg::t_item               i_q_item,
    output logic                         o_pop,
    input  wire                          i_cfg_valid,
    input  wire  [kmp_pkg::IDX_W-1:0]    i_cfg_index,
    input  wire  [kmp_pkg::CFG_W-1:0]    i_cfg_data,
    output logic                         o_m_tvalid,
    input  wire                          i_m_tready,
    output logic [kmp_pkg::M_DATA_W-1:0] o_m_tdata,
    output logic [kmp_pkg::ACT_W-1:0]    o_m_tuser
);
    import kmp_pkg::*;

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam logic [CW-1:0] C_ONE   = CW'(1);
    localparam logic [CW-1:0] C_DEPTH = CW'(BUFFER_DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic [KEY_W+MOD_W-1:0] mem [0:BUFFER_DEPTH-1];
    logic [KEY_W+MOD_W-1:0] r_rdata;

    logic             r_state, n_state;
    logic [CW-1:0]    r_fill, n_fill;
    logic [CW-1:0]    r_pos, n_pos;
    logic [7:0]       r_pause, n_pause;
    logic [KEY_W-1:0] r_held, n_held;
    logic [MOD_W-1:0] r_mods, n_mods;
    logic             r_playing, n_playing;

    logic [CFG_W-1:0] r_media_first, r_media_last, r_power_first, r_power_last;

    logic             r_out_valid, n_out_valid;
    logic [ACT_W-1:0] r_out_act, n_out_act;
    logic [KEY_W-1:0] r_out_code, n_out_code;
    logic [MOD_W-1:0] r_out_mods;

    logic             out_free;
    logic             produce;
    logic             mem_we;
    logic             mem_re;
    logic [KEY_W-1:0] w_key;
    logic [MOD_W-1:0] w_mod;
    logic             held_media, held_power, key_media, key_power;

    assign out_free = !r_out_valid || i_m_tready;
    assign o_pop    = (r_state == ST_IDLE) && i_q_valid && out_free;
    assign w_key    = r_rdata[KEY_W-1:0];
    assign w_mod    = r_rdata[KEY_W+MOD_W-1:KEY_W];

    assign held_media = (r_held >= r_media_first) && (r_held <= r_media_last);
    assign held_power = (r_held >= r_power_first) && (r_held <= r_power_last);
    assign key_media  = (w_key >= r_media_first) && (w_key <= r_media_last);
    assign key_power  = (w_key >= r_power_first) && (w_key <= r_power_last);

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_pos       = r_pos;
        n_pause     = r_pause;
        n_held      = r_held;
        n_mods      = r_mods;
        n_playing   = r_playing;
        n_out_act   = ACT_NONE;
        n_out_code  = '0;
        produce     = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    case (i_q_item.kind)
                        KIND_APPEND: begin
                            produce = 1'b1;
                            if (r_fill >= C_DEPTH) begin
                                n_out_act = ACT_REJECTED;
                            end else begin
                                mem_we    = 1'b1;
                                n_fill    = r_fill + C_ONE;
                                n_playing = 1'b1;
                                n_out_act = ACT_ACCEPTED;
                            end
                        end
                        KIND_TICK: begin
                            // The word at the play position is read first; the
                            // step itself runs on the registered read data.
                            mem_re  = 1'b1;
                            n_state = ST_EXEC;
                        end
                        default: begin
                            produce = 1'b1;
                        end
                    endcase
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    produce = 1'b1;
                    n_state = ST_IDLE;
                    if (r_fill == '0) begin
                        if (r_playing) begin
                            n_playing = 1'b0;
                            n_out_act = ACT_FINISHED;
                        end
                    end else if (r_pause != 8'd0) begin
                        n_pause = r_pause - 8'd1;
                    end else if (r_held != '0) begin
                        n_held = '0;
                        if (r_held < KEY_HIGH) begin
                            n_out_act  = ACT_KEY_UP;
                            n_out_code = r_held;
                        end else if (held_media) begin
                            n_out_act  = ACT_MEDIA_UP;
                            n_out_code = r_held;
                        end else if (held_power) begin
                            n_out_act  = ACT_POWER_UP;
                            n_out_code = r_held;
                        end
                    end else if (r_pos >= r_fill) begin
                        n_fill = '0;
                        n_pos  = '0;
                    end else if (w_key == KEY_PAUSE) begin
                        n_pause = w_mod;
                        n_pos   = r_pos + C_ONE;
                    end else if (r_mods != w_mod) begin
                        n_mods    = w_mod;
                        n_out_act = ACT_MODS;
                    end else begin
                        n_held = w_key;
                        n_pos  = r_pos + C_ONE;
                        if (w_key != '0 && w_key < KEY_HIGH) begin
                            n_out_act  = ACT_KEY_DN;
                            n_out_code = w_key;
                        end else if (w_key >= KEY_HIGH && key_media) begin
                            n_out_act  = ACT_MEDIA_DN;
                            n_out_code = w_key;
                        end else if (w_key >= KEY_HIGH && key_power) begin
                            n_out_act  = ACT_POWER_DN;
                            n_out_code = w_key;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_valid = produce ? 1'b1 : (r_out_valid && !i_m_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_fill        <= '0;
            r_pos         <= '0;
            r_pause       <= '0;
            r_held        <= '0;
            r_mods        <= '0;
            r_playing     <= 1'b0;
            r_out_valid   <= 1'b0;
            r_media_first <= MEDIA_FIRST_RST;
            r_media_last  <= MEDIA_LAST_RST;
            r_power_first <= POWER_FIRST_RST;
            r_power_last  <= POWER_LAST_RST;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_pos       <= n_pos;
            r_pause     <= n_pause;
            r_held      <= n_held;
            r_mods      <= n_mods;
            r_playing   <= n_playing;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_MEDIA_FIRST: r_media_first <= i_cfg_data;
                    REG_MEDIA_LAST:  r_media_last  <= i_cfg_data;
                    REG_POWER_FIRST: r_power_first <= i_cfg_data;
                    REG_POWER_LAST:  r_power_last  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_out_act  <= n_out_act;
            r_out_code <= n_out_code;
            r_out_mods <= n_mods;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_fill[AW-1:0]] <= {i_q_item.mods, i_q_item.key};
        end
        if (mem_re) begin
            r_rdata <= mem[r_pos[AW-1:0]];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_act;
    assign o_m_tdata  = {r_out_mods, r_out_code};

endmodule
`default_nettype wire

// ----- design/keystroke_macro_player_top.sv -----
`default_nettype none
// Keystroke macro player. Append words (tuser 0) store a key byte and a
// modifier byte in a word buffer of BUFFER_DEPTH entries; tick words (tuser 1)
// play the buffer one step at a time, and every input word gives exactly one
// result word, with the action code on tuser. Input words pass a register
// stage and a two-entry queue before the player. An append or a tick with
// host_busy set is handled in the player's idle state; any other tick also
// passes an execute state, because the buffer word at the play position is
// read from a memory with a registered read port before the step is taken.
// Sustained rate is one append per cycle while the output is not stalled; the
// player takes no new word from the queue until a tick's step is done. The
// buffer needs no clearing after reset. The user must write the range
// registers through the configuration channel, which is always ready, only
// while the block is idle; the block itself does not enforce this.
module keystroke_macro_player_top #(
    parameter int BUFFER_DEPTH = kmp_pkg::BUFFER_DEPTH_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_s_tvalid,
    output logic                         o_s_tready,
    // key_byte [7:0], modifier_byte [15:8], host_busy [16], zero [23:17]
    input  wire  [kmp_pkg::S_DATA_W-1:0] i_s_tdata,
    // operation [0]
    input  wire                          i_s_tuser,
    output logic                         o_m_tvalid,
    input  wire                          i_m_tready,
    // code [7:0], modifiers [15:8]
    output logic [kmp_pkg::M_DATA_W-1:0] o_m_tdata,
    // action [3:0]
    output logic [kmp_pkg::ACT_W-1:0]    o_m_tuser,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [kmp_pkg::IDX_W-1:0]    i_cfg_index,
    input  wire  [kmp_pkg::CFG_W-1:0]    i_cfg_data
);
    import kmp_pkg::*;

    logic  push;
    logic  q_ready;
    logic  q_valid;
    logic  pop;
    t_item front_item;
    t_item q_item;

    assign o_cfg_ready = 1'b1;

    kmp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_push     (push),
        .o_item     (front_item),
        .i_q_ready  (q_ready)
    );

    kmp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (pop)
    );

    kmp_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_pop       (pop),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule
`default_nettype wire

// ----- design/kmp_checker.sv -----
`default_nettype none
module kmp_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          o_m_tvalid,
    input wire                          i_m_tready,
    input wire [kmp_pkg::M_DATA_W-1:0]  o_m_tdata,
    input wire [kmp_pkg::ACT_W-1:0]     o_m_tuser
);
    import kmp_pkg::*;

    // A result word that waits must keep its contents.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser)))
        else $error("stalled result changed");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser <= ACT_REJECTED))
        else $error("action code out of range");

    // Only press and release results carry a key code.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == ACT_NONE || o_m_tuser == ACT_MODS
            || o_m_tuser == ACT_FINISHED || o_m_tuser == ACT_ACCEPTED
            || o_m_tuser == ACT_REJECTED)) |-> (o_m_tdata[7:0] == 8'd0))
        else $error("key code on a result without a key");

    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind keystroke_macro_player_top kmp_checker u_kmp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
`default_nettype wire

// ----- verif/keystroke_macro_player_checker.sv -----
module keystroke_macro_player_checker
    import kmp_pkg::*;
#(
    parameter int DEPTH = BUFFER_DEPTH_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_s_tvalid,
    input  wire                  i_s_tready,
    // key_byte [7:0], modifier_byte [15:8], host_busy [16], zero [23:17]
    input  wire  [S_DATA_W-1:0]  i_s_tdata,
    // operation [0]
    input  wire                  i_s_tuser,
    input  wire                  i_m_tvalid,
    input  wire                  i_m_tready,
    // code [7:0], modifiers [15:8]
    input  wire  [M_DATA_W-1:0]  i_m_tdata,
    // action [3:0]
    input  wire  [ACT_W-1:0]     i_m_tuser,
    input  wire                  i_cfg_valid,
    input  wire                  i_cfg_ready,
    input  wire  [IDX_W-1:0]     i_cfg_index,
    input  wire  [CFG_W-1:0]     i_cfg_data,
    output int                   o_mismatches,
    output int                   o_pending,
    output int                   o_results,
    output logic [10:0]          o_act_seen
);

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [KEY_W-1:0] code;
        logic [MOD_W-1:0] mods;
    } keystep_t;

    keystep_t expected_steps[$];

    // Shadow copy of the player state and the range registers.
    logic [15:0]      word_mem [DEPTH];
    int unsigned      fill_cnt;
    int unsigned      play_pos;
    logic [7:0]       pause_cnt;
    logic [KEY_W-1:0] held;
    logic [MOD_W-1:0] cur_mods;
    logic             playing_q;
    logic [CFG_W-1:0] media_lo, media_hi, power_lo, power_hi;

    function automatic logic is_media(logic [KEY_W-1:0] k);
        return k >= media_lo && k <= media_hi;
    endfunction

    function automatic logic is_power(logic [KEY_W-1:0] k);
        return k >= power_lo && k <= power_hi;
    endfunction

    function automatic keystep_t advance_tick();
        keystep_t         r;
        logic [15:0]      w;
        logic [KEY_W-1:0] k;
        logic [MOD_W-1:0] m;
        r.action = ACT_NONE;
        r.code   = '0;
        r.mods   = '0;
        if (fill_cnt == 0) begin
            if (playing_q) begin
                playing_q = 1'b0;
                r.action  = ACT_FINISHED;
            end
        end else if (pause_cnt != 0) begin
            pause_cnt = pause_cnt - 8'd1;
        end else if (held != 0) begin
            if (held < KEY_HIGH) begin
                r.action = ACT_KEY_UP;
            end else if (is_media(held)) begin
                r.action = ACT_MEDIA_UP;
            end else if (is_power(held)) begin
                r.action = ACT_POWER_UP;
            end
            if (r.action != ACT_NONE) begin
                r.code = held;
            end
            held = '0;
        end else if (play_pos >= fill_cnt) begin
            // Every word has been played: the buffer empties.
            fill_cnt = 0;
            play_pos = 0;
        end else begin
            w = word_mem[play_pos];
            k = w[7:0];
            m = w[15:8];
            if (k == KEY_PAUSE) begin
                pause_cnt = m;
                play_pos++;
            end else if (cur_mods != m) begin
                cur_mods = m;
                r.action = ACT_MODS;
            end else begin
                held = k;
                if (k != 0 && k < KEY_HIGH) begin
                    r.action = ACT_KEY_DN;
                end else if (k >= KEY_HIGH && is_media(k)) begin
                    r.action = ACT_MEDIA_DN;
                end else if (k >= KEY_HIGH && is_power(k)) begin
                    r.action = ACT_POWER_DN;
                end
                if (r.action != ACT_NONE) begin
                    r.code = k;
                end
                play_pos++;
            end
        end
        return r;
    endfunction

    function automatic keystep_t predict_step(logic op, logic [KEY_W-1:0] key,
                                              logic [MOD_W-1:0] mods, logic busy);
        keystep_t r;
        r.action = ACT_NONE;
        r.code   = '0;
        if (op == KIND_APPEND[0]) begin
            if (fill_cnt >= DEPTH) begin
                r.action = ACT_REJECTED;
            end else begin
                word_mem[fill_cnt] = {mods, key};
                fill_cnt++;
                playing_q = 1'b1;
                r.action  = ACT_ACCEPTED;
            end
        end else if (!busy) begin
            r = advance_tick();
        end
        r.mods = cur_mods;
        return r;
    endfunction

    always @(posedge i_clk) begin
        keystep_t want, got;
        if (!i_rst_n) begin
            fill_cnt     = 0;
            play_pos     = 0;
            pause_cnt    = '0;
            held         = '0;
            cur_mods     = '0;
            playing_q    = 1'b0;
            media_lo     = MEDIA_FIRST_RST;
            media_hi     = MEDIA_LAST_RST;
            power_lo     = POWER_FIRST_RST;
            power_hi     = POWER_LAST_RST;
            expected_steps.delete();
            o_mismatches = 0;
            o_pending    = 0;
            o_results    = 0;
            o_act_seen   = '0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_MEDIA_FIRST: media_lo = i_cfg_data;
                    REG_MEDIA_LAST:  media_hi = i_cfg_data;
                    REG_POWER_FIRST: power_lo = i_cfg_data;
                    REG_POWER_LAST:  power_hi = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_steps.push_back(predict_step(i_s_tuser, i_s_tdata[7:0],
                                                      i_s_tdata[15:8], i_s_tdata[16]));
            end
            if (i_m_tvalid && i_m_tready) begin
                got.action = i_m_tuser;
                got.code   = i_m_tdata[7:0];
                got.mods   = i_m_tdata[15:8];
                o_results++;
                if (got.action <= ACT_REJECTED) begin
                    o_act_seen[got.action] = 1'b1;
                end
                if (expected_steps.size() == 0) begin
                    if (o_mismatches < 10) begin
                        $display("%0t: result word with nothing expected: action %0d code %h mods %h",
                                 $time, got.action, got.code, got.mods);
                    end
                    o_mismatches++;
                end else begin
                    want = expected_steps.pop_front();
                    if (got.action !== want.action || got.code !== want.code ||
                        got.mods !== want.mods) begin
                        if (o_mismatches < 10) begin
                            $display("%0t: mismatch: expected action %0d code %h mods %h, got action %0d code %h mods %h",
                                     $time, want.action, want.code, want.mods,
                                     got.action, got.code, got.mods);
                        end
                        o_mismatches++;
                    end
                end
            end
            o_pending = expected_steps.size();
        end
    end

endmodule

// ----- verif/keystroke_macro_player_top_test.sv -----
module keystroke_macro_player_top_test;
    import kmp_pkg::*;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic [ACT_W-1:0]    m_tuser;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    int                  mismatches;
    int                  pending;
    int                  results;
    logic [10:0]         act_seen;

    int                  words_sent;
    int                  hold_cycles;
    int                  settings_run;
    logic                src_idle;
    logic                sink_idle;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    keystroke_macro_player_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    keystroke_macro_player_checker #(.DEPTH(BUFFER_DEPTH_DEF)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_results    (results),
        .o_act_seen   (act_seen)
    );

    // Every task below starts and ends at a falling edge.
    task automatic put_word(logic op, logic [KEY_W-1:0] key, logic [MOD_W-1:0] mods,
                            logic busy);
        if (src_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {7'd0, busy, mods, key};
        s_tuser  = op;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        words_sent++;
    endtask

    task automatic append_word(logic [KEY_W-1:0] key, logic [MOD_W-1:0] mods);
        put_word(KIND_APPEND[0], key, mods, 1'($urandom_range(0, 1)));
    endtask

    task automatic tick(logic busy);
        put_word(KIND_TICK[0], 8'($urandom), 8'($urandom), busy);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic set_ranges(logic [7:0] mf, logic [7:0] ml, logic [7:0] pf, logic [7:0] pl);
        write_reg(REG_MEDIA_FIRST, mf);
        write_reg(REG_MEDIA_LAST, ml);
        write_reg(REG_POWER_FIRST, pf);
        write_reg(REG_POWER_LAST, pl);
        // An index past the last register must be ignored.
        write_reg(IDX_W'($urandom_range(int'(REG_POWER_LAST) + 1, 255)), 8'($urandom));
        cfg_valid = 1'b0;
        settings_run++;
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return '0;
        if (r <= 2) return KEY_PAUSE;
        if (r <= 8) return KEY_W'($urandom_range(2, 127));
        if (r <= 14) return KEY_W'($urandom_range(128, 255));
        return KEY_W'($urandom);
    endfunction

    function automatic logic [MOD_W-1:0] pick_mods(logic [KEY_W-1:0] key);
        logic [MOD_W-1:0] pool [4];
        pool = '{8'h00, 8'h02, 8'h20, 8'hFF};
        // Long pauses are rare so that the run stays short.
        if (key == KEY_PAUSE) begin
            if ($urandom_range(0, 49) == 0) return MOD_W'($urandom);
            return MOD_W'($urandom_range(0, 4));
        end
        if ($urandom_range(0, 3) == 0) return MOD_W'($urandom);
        return pool[$urandom_range(0, 3)];
    endfunction

    function automatic int word_ticks(logic [KEY_W-1:0] key, logic [MOD_W-1:0] mods);
        return 3 + ((key == KEY_PAUSE) ? int'(mods) : 0);
    endfunction

    // Loads a macro and then ticks until it has surely played out, with busy
    // ticks and appends while playing mixed in.
    task automatic run_macro(int n_words);
        int               budget;
        int               r;
        logic [KEY_W-1:0] k;
        logic [MOD_W-1:0] m;
        budget = 3;
        for (int i = 0; i < n_words; i++) begin
            k = pick_key();
            m = pick_mods(k);
            append_word(k, m);
            budget += word_ticks(k, m);
        end
        while (budget > 0) begin
            r = $urandom_range(0, 19);
            if (r < 3) begin
                tick(1'b1);
            end else if (r == 3) begin
                k = pick_key();
                m = pick_mods(k);
                append_word(k, m);
                budget += word_ticks(k, m);
            end else begin
                tick(1'b0);
                budget--;
            end
        end
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) begin
            put_word(1'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic run_random(int n_items);
        int stop_at;
        stop_at = words_sent + n_items;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 7) == 0) begin
                send_noise();
            end else if ($urandom_range(0, 9) == 0) begin
                run_macro($urandom_range(30, 34));
            end else begin
                run_macro($urandom_range(1, 8));
            end
        end
    endtask

    // Receiver: random bursts of back-pressure, or one long hold on request.
    initial begin
        m_tready = 1'b1;
        forever begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                m_tready = 1'b0;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
                m_tready = 1'b1;
            end else if (sink_idle && $urandom_range(0, 4) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                m_tready = 1'b1;
            end
        end
    end

    initial begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        words_sent   = 0;
        hold_cycles  = 0;
        settings_run = 1;
        src_idle     = 1'b1;
        sink_idle    = 1'b1;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty and busy ticks, then one word of each kind.
        tick(1'b0);
        tick(1'b1);
        append_word(8'h7F, 8'hFF);
        append_word(KEY_PAUSE, 8'h02);
        append_word(8'h00, 8'hFF);
        append_word(8'h80, 8'hFF);
        append_word(8'h92, 8'hFF);
        append_word(8'hFF, 8'h00);
        append_word(KEY_PAUSE, 8'h00);
        for (int i = 0; i < 18; i++) begin
            tick(i == 5);
        end
        drain();

        set_ranges(MEDIA_FIRST_RST, MEDIA_LAST_RST, POWER_FIRST_RST, POWER_LAST_RST);
        run_random(200);
        drain();

        // Overlapping ranges: media wins. The output is held off for a long
        // stretch so that the input side backs up.
        set_ranges(8'd128, 8'd255, 8'd128, 8'd255);
        hold_cycles = 300;
        run_macro(20);
        run_random(200);
        drain();

        // Empty media range, everything high is a power key.
        set_ranges(8'd255, 8'd128, 8'd128, 8'd255);
        run_random(250);
        drain();

        set_ranges(8'd255, 8'd255, 8'd128, 8'd128);
        run_random(250);
        drain();

        set_ranges(8'($urandom_range(128, 255)), 8'($urandom_range(128, 255)),
                   8'($urandom_range(128, 255)), 8'($urandom_range(128, 255)));
        run_random(250);
        drain();

        // Last stretch runs at full rate on both sides.
        set_ranges(8'($urandom_range(128, 160)), 8'($urandom_range(140, 200)),
                   8'($urandom_range(150, 255)), 8'($urandom_range(150, 255)));
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        run_random(250);
        drain();
        repeat (10) @(negedge clk);

        $display("Run covered %0d input words, %0d result words, %0d range settings.",
                 words_sent, results, settings_run);
        $display("Action codes seen (bit per code, 10 down to 0): %b", act_seen);
        if (mismatches == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Timeout with %0d result words still expected.", pending);
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
design/kmp_pkg.sv
design/kmp_front.sv
design/kmp_queue.sv
design/kmp_back.sv
design/keystroke_macro_player_top.sv
design/kmp_checker.sv
verif/keystroke_macro_player_checker.sv
verif/keystroke_macro_player_top_test.sv
